/* rtl/core/jda_pkg.sv */
// Shared types, constants and helpers for the Jacobian determinant / adjugate block.
// No dependencies; used by the front, queue and back modules and the top level.
`timescale 1ns / 1ps
package jda_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] YK_J     = 2'd0;
  localparam logic [1:0] YK_CONST = 2'd1;
  localparam logic [1:0] YK_FULL  = 2'd2;

  localparam logic [1:0] DIM_ONE   = 2'd1;
  localparam logic [1:0] DIM_TWO   = 2'd2;
  localparam logic [1:0] DIM_THREE = 2'd3;

  localparam logic [63:0]  ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [111:0] SCALE_Q16 = 112'd65536;

  typedef struct packed {
    logic [8:0][47:0] jac;
    logic [2:0][47:0] crd;
    logic [1:0]       dim;
    logic             last_point;
  } pt_t;

  typedef struct packed {
    logic [QCW-1:0] cnt;
    logic           full;
    logic           empty;
  } q_stat_t;

  typedef struct packed {
    logic [3:0] xs;
    logic [1:0] ykind;
    logic [3:0] ys;
    logic       neg;
    logic       last;
    logic       ddet;
    logic [3:0] didx;
    logic       fwr;
    logic [1:0] fidx;
  } step_t;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (!((&v[47:31]) || !(|v[47:31]))) r = v[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [159:0] v);
    logic signed [63:0] r;
    if (!((&v[159:63]) || !(|v[159:63]))) r = v[159] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = v[63:0];
    return r;
  endfunction

  function automatic step_t mk(input logic [3:0] xs, input logic [1:0] yk, input logic [3:0] ys,
                               input logic neg, input logic last, input logic ddet,
                               input logic [3:0] didx, input logic fwr, input logic [1:0] fidx);
    step_t s;
    s.xs = xs; s.ykind = yk; s.ys = ys; s.neg = neg; s.last = last;
    s.ddet = ddet; s.didx = didx; s.fwr = fwr; s.fidx = fidx;
    return s;
  endfunction

  function automatic step_t seq_step(input logic [1:0] dim, input logic [4:0] step);
    step_t s;
    s = mk(4'd0, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
    case (dim)
      DIM_THREE: begin
        case (step)
          5'd0:  s = mk(4'd4, YK_J, 4'd8, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 2'd0);
          5'd1:  s = mk(4'd5, YK_J, 4'd7, 1'b1, 1'b1, 1'b0, 4'd0, 1'b1, 2'd0);
          5'd2:  s = mk(4'd7, YK_J, 4'd2, 1'b0, 1'b0, 1'b0, 4'd1, 1'b0, 2'd0);
          5'd3:  s = mk(4'd8, YK_J, 4'd1, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0, 2'd0);
          5'd4:  s = mk(4'd1, YK_J, 4'd5, 1'b0, 1'b0, 1'b0, 4'd2, 1'b0, 2'd0);
          5'd5:  s = mk(4'd2, YK_J, 4'd4, 1'b1, 1'b1, 1'b0, 4'd2, 1'b0, 2'd0);
          5'd6:  s = mk(4'd5, YK_J, 4'd6, 1'b0, 1'b0, 1'b0, 4'd3, 1'b0, 2'd0);
          5'd7:  s = mk(4'd3, YK_J, 4'd8, 1'b1, 1'b1, 1'b0, 4'd3, 1'b1, 2'd1);
          5'd8:  s = mk(4'd8, YK_J, 4'd0, 1'b0, 1'b0, 1'b0, 4'd4, 1'b0, 2'd0);
          5'd9:  s = mk(4'd6, YK_J, 4'd2, 1'b1, 1'b1, 1'b0, 4'd4, 1'b0, 2'd0);
          5'd10: s = mk(4'd2, YK_J, 4'd3, 1'b0, 1'b0, 1'b0, 4'd5, 1'b0, 2'd0);
          5'd11: s = mk(4'd0, YK_J, 4'd5, 1'b1, 1'b1, 1'b0, 4'd5, 1'b0, 2'd0);
          5'd12: s = mk(4'd3, YK_J, 4'd7, 1'b0, 1'b0, 1'b0, 4'd6, 1'b0, 2'd0);
          5'd13: s = mk(4'd4, YK_J, 4'd6, 1'b1, 1'b1, 1'b0, 4'd6, 1'b1, 2'd2);
          5'd14: s = mk(4'd6, YK_J, 4'd1, 1'b0, 1'b0, 1'b0, 4'd7, 1'b0, 2'd0);
          5'd15: s = mk(4'd7, YK_J, 4'd0, 1'b1, 1'b1, 1'b0, 4'd7, 1'b0, 2'd0);
          5'd16: s = mk(4'd0, YK_J, 4'd4, 1'b0, 1'b0, 1'b0, 4'd8, 1'b0, 2'd0);
          5'd17: s = mk(4'd1, YK_J, 4'd3, 1'b1, 1'b1, 1'b0, 4'd8, 1'b0, 2'd0);
          5'd18: s = mk(4'd0, YK_FULL, 4'd0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 2'd0);
          5'd19: s = mk(4'd1, YK_FULL, 4'd1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 2'd0);
          5'd20: s = mk(4'd2, YK_FULL, 4'd2, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
          default: s = mk(4'd0, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
        endcase
      end
      DIM_TWO: begin
        case (step)
          5'd0: s = mk(4'd4, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0, 2'd0);
          5'd1: s = mk(4'd1, YK_CONST, 4'd0, 1'b1, 1'b1, 1'b0, 4'd1, 1'b0, 2'd0);
          5'd2: s = mk(4'd3, YK_CONST, 4'd0, 1'b1, 1'b1, 1'b0, 4'd3, 1'b0, 2'd0);
          5'd3: s = mk(4'd0, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b0, 4'd4, 1'b0, 2'd0);
          5'd4: s = mk(4'd0, YK_J, 4'd4, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 2'd0);
          5'd5: s = mk(4'd1, YK_J, 4'd3, 1'b1, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
          default: s = mk(4'd0, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
        endcase
      end
      default: s = mk(4'd0, YK_CONST, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 2'd0);
    endcase
    return s;
  endfunction

  function automatic logic [4:0] seq_last(input logic [1:0] dim);
    logic [4:0] r;
    case (dim)
      DIM_THREE: r = 5'd20;
      DIM_TWO:   r = 5'd5;
      default:   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/jda_in_if.sv */
// Node word channel: valid/ready handshake with the node payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface jda_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] shape_value;
  logic signed [17:0] shape_d_r1;
  logic signed [17:0] shape_d_r2;
  logic signed [17:0] shape_d_r3;
  logic signed [31:0] node_x;
  logic signed [31:0] node_y;
  logic signed [31:0] node_z;
  logic               last_node;
  logic               last_point;

  modport source (output valid, shape_value, shape_d_r1, shape_d_r2, shape_d_r3,
                  node_x, node_y, node_z, last_node, last_point, input ready);
  modport sink (input valid, shape_value, shape_d_r1, shape_d_r2, shape_d_r3,
                node_x, node_y, node_z, last_node, last_point, output ready);
endinterface

/* rtl/core/jda_out_if.sv */
// Result word channel: valid/ready handshake with one adjugate row per word.
// Depends on nothing.
`timescale 1ns / 1ps
interface jda_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [63:0] adj_col0;
  logic signed [63:0] adj_col1;
  logic signed [63:0] adj_col2;
  logic signed [31:0] point_coord;
  logic signed [63:0] determinant;
  logic               last_row;
  logic               point_done_last;

  modport source (output valid, row_index, adj_col0, adj_col1, adj_col2, point_coord,
                  determinant, last_row, point_done_last, input ready);
  modport sink (input valid, row_index, adj_col0, adj_col1, adj_col2, point_coord,
                determinant, last_row, point_done_last, output ready);
endinterface

/* rtl/core/jda_front.sv */
// Front end: accepts node words, forms the twelve shape-by-coordinate products and
// accumulates them; pushes the finished point into the queue. Uses jda_pkg, jda_in_if.
`timescale 1ns / 1ps
module jda_front #(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  jda_in_if.sink           in_ch,
  input  logic [1:0]       dim_mode,
  input  jda_pkg::q_stat_t q_stat,
  output logic             push,
  output jda_pkg::pt_t     push_data
);

  localparam int CW = $clog2(MAX_NODES + 1);

  logic               s1_vld_r, s1_last_r, s1_lp_r, s1_add_r;
  logic signed [49:0] s1_prod_r [12];
  logic signed [49:0] prod_nxt [12];
  logic signed [47:0] acc_r [12];
  logic signed [47:0] acc_nxt [12];
  logic [CW-1:0]      cnt_r;
  logic signed [17:0] sh [4];
  logic signed [31:0] xc [3];
  logic               accept;
  logic [jda_pkg::QCW:0] busy;

  assign busy        = {1'b0, q_stat.cnt} + {{jda_pkg::QCW{1'b0}}, s1_vld_r & s1_last_r};
  assign in_ch.ready = busy < (jda_pkg::QCW + 1)'(jda_pkg::QDEPTH);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    sh[0] = in_ch.shape_value;
    sh[1] = in_ch.shape_d_r1;
    sh[2] = in_ch.shape_d_r2;
    sh[3] = in_ch.shape_d_r3;
    xc[0] = in_ch.node_x;
    xc[1] = in_ch.node_y;
    xc[2] = in_ch.node_z;
    for (int b = 0; b < 3; b++) begin
      prod_nxt[b] = sh[0] * xc[b];
      for (int a = 0; a < 3; a++) begin
        prod_nxt[3 + a * 3 + b] = sh[a + 1] * xc[b];
      end
    end
  end

  always_comb begin
    logic signed [49:0] rnd;
    logic signed [49:0] t;
    for (int k = 0; k < 12; k++) begin
      rnd = s1_prod_r[k] + 50'sd8192;
      t   = rnd >>> 14;
      acc_nxt[k] = acc_r[k];
      if (s1_vld_r && s1_add_r) begin
        acc_nxt[k] = jda_pkg::sat48({acc_r[k][47], acc_r[k]} + t[48:0]);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      push_data.crd[b] = acc_nxt[b];
    end
    for (int k = 0; k < 9; k++) begin
      push_data.jac[k] = acc_nxt[3 + k];
    end
    push_data.dim        = (dim_mode == 2'd0) ? jda_pkg::DIM_ONE : dim_mode;
    push_data.last_point = s1_lp_r;
  end

  assign push = s1_vld_r && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      cnt_r    <= '0;
      for (int k = 0; k < 12; k++) acc_r[k] <= '0;
    end else begin
      s1_vld_r <= accept;
      if (accept) begin
        if (in_ch.last_node) cnt_r <= '0;
        else if (cnt_r < CW'(MAX_NODES)) cnt_r <= cnt_r + CW'(1);
      end
      for (int k = 0; k < 12; k++) acc_r[k] <= push ? '0 : acc_nxt[k];
    end
    if (accept) begin
      s1_last_r <= in_ch.last_node;
      s1_lp_r   <= in_ch.last_point;
      s1_add_r  <= cnt_r < CW'(MAX_NODES);
      for (int k = 0; k < 12; k++) s1_prod_r[k] <= prod_nxt[k];
    end
  end

endmodule

/* rtl/core/jda_queue.sv */
// Point queue between front and back: two entries of finished accumulators.
// Uses jda_pkg.
`timescale 1ns / 1ps
module jda_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jda_pkg::pt_t     push_data,
  input  logic             pop,
  output jda_pkg::pt_t     head,
  output jda_pkg::q_stat_t q_stat
);

  jda_pkg::pt_t              mem_r [jda_pkg::QDEPTH];
  logic [jda_pkg::QAW-1:0]   wr_r, rd_r;
  logic [jda_pkg::QCW-1:0]   cnt_r;

  assign head         = mem_r[rd_r];
  assign q_stat.cnt   = cnt_r;
  assign q_stat.full  = cnt_r == jda_pkg::QCW'(jda_pkg::QDEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + jda_pkg::QAW'(1);
      if (pop)  rd_r <= rd_r + jda_pkg::QAW'(1);
      if (push && !pop)      cnt_r <= cnt_r + jda_pkg::QCW'(1);
      else if (pop && !push) cnt_r <= cnt_r - jda_pkg::QCW'(1);
    end
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

/* rtl/core/jda_back.sv */
// Back end: sequences the adjugate and determinant through one 48x16 digit multiplier
// and a wide accumulator, then emits one row word per axis. Uses jda_pkg, jda_out_if.
`timescale 1ns / 1ps
module jda_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jda_pkg::pt_t     head,
  input  jda_pkg::q_stat_t q_stat,
  output logic             pop,
  jda_out_if.source        out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LDX   = 3'd1;
  localparam logic [2:0] S_LDY   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]          state_r;
  logic signed [47:0]  jac_r [9];
  logic signed [47:0]  crd_r [3];
  logic [1:0]          dim_r;
  logic                lp_r;
  logic signed [63:0]  adj_r [9];
  logic signed [96:0]  full_r [3];
  logic signed [63:0]  det_r;
  logic [4:0]          step_r;
  logic [47:0]         xmag_r;
  logic [111:0]        ymag_r;
  logic                psign_r;
  logic [2:0]          ndig_r, dig_r;
  logic [63:0]         pp_r;
  logic [159:0]        prod_r;
  logic signed [159:0] sum_r;
  logic [1:0]          row_r;
  jda_pkg::step_t      st;
  logic signed [47:0]  jrd;
  logic [3:0]          jaddr;
  logic signed [96:0]  frd;
  logic                out_vld_r;
  logic [1:0]          o_row_r;
  logic signed [63:0]  o_c0_r, o_c1_r, o_c2_r, o_det_r;
  logic signed [31:0]  o_crd_r;
  logic                o_last_r, o_lp_r;
  logic                out_free;

  assign st       = jda_pkg::seq_step(dim_r, step_r);
  assign jaddr    = (state_r == S_LDX) ? st.xs : st.ys;
  assign jrd      = jac_r[jaddr];
  assign frd      = full_r[st.ys[1:0]];
  assign out_free = !out_vld_r || out_ch.ready;
  assign pop      = (state_r == S_IDLE) && !q_stat.empty;

  assign out_ch.valid           = out_vld_r;
  assign out_ch.row_index       = o_row_r;
  assign out_ch.adj_col0        = o_c0_r;
  assign out_ch.adj_col1        = o_c1_r;
  assign out_ch.adj_col2        = o_c2_r;
  assign out_ch.point_coord     = o_crd_r;
  assign out_ch.determinant     = o_det_r;
  assign out_ch.last_row        = o_last_r;
  assign out_ch.point_done_last = o_lp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) state_r <= S_LDX;
        end
        S_LDX: state_r <= S_LDY;
        S_LDY: state_r <= S_MUL;
        S_MUL: state_r <= S_ADD;
        S_ADD: begin
          if (dig_r + 3'd1 == ndig_r) state_r <= S_SUM;
          else state_r <= S_MUL;
        end
        S_SUM: begin
          state_r <= st.last ? S_STORE : S_LDX;
        end
        S_STORE: begin
          state_r <= (step_r == jda_pkg::seq_last(dim_r)) ? S_EMIT : S_LDX;
        end
        S_EMIT: begin
          if (out_free) begin
            if (row_r == dim_r - 2'd1) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        for (int k = 0; k < 9; k++) begin
          jac_r[k] <= head.jac[k];
          adj_r[k] <= (k == 0 && head.dim == jda_pkg::DIM_ONE) ? jda_pkg::ONE_Q32 : '0;
        end
        for (int b = 0; b < 3; b++) crd_r[b] <= head.crd[b];
        dim_r  <= head.dim;
        lp_r   <= head.last_point;
        step_r <= '0;
        sum_r  <= '0;
        row_r  <= '0;
      end
      S_LDX: begin
        xmag_r  <= jrd[47] ? 48'(-jrd) : jrd;
        psign_r <= jrd[47] ^ st.neg;
        prod_r  <= '0;
        dig_r   <= '0;
      end
      S_LDY: begin
        case (st.ykind)
          jda_pkg::YK_J: begin
            ymag_r  <= {64'd0, (jrd[47] ? 48'(-jrd) : jrd)};
            psign_r <= psign_r ^ jrd[47];
            ndig_r  <= 3'd3;
          end
          jda_pkg::YK_FULL: begin
            ymag_r  <= {15'd0, (frd[96] ? 97'(-frd) : frd)};
            psign_r <= psign_r ^ frd[96];
            ndig_r  <= 3'd7;
          end
          default: begin
            ymag_r <= jda_pkg::SCALE_Q16;
            ndig_r <= 3'd2;
          end
        endcase
      end
      S_MUL: begin
        pp_r <= xmag_r * ymag_r[{dig_r, 4'd0} +: 16];
      end
      S_ADD: begin
        prod_r <= prod_r + ({96'd0, pp_r} << {dig_r, 4'd0});
        dig_r  <= dig_r + 3'd1;
      end
      S_SUM: begin
        sum_r <= sum_r + (psign_r ? -prod_r : prod_r);
        if (!st.last) step_r <= step_r + 5'd1;
      end
      S_STORE: begin
        if (st.ddet) begin
          det_r <= (dim_r == jda_pkg::DIM_THREE) ? jda_pkg::sat64(sum_r >>> 16)
                                                 : jda_pkg::sat64(sum_r);
        end else begin
          adj_r[st.didx] <= jda_pkg::sat64(sum_r);
          if (st.fwr) full_r[st.fidx] <= sum_r[96:0];
        end
        sum_r  <= '0;
        step_r <= step_r + 5'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          o_row_r  <= row_r;
          o_c0_r   <= adj_r[0];
          o_c1_r   <= adj_r[1];
          o_c2_r   <= adj_r[2];
          o_crd_r  <= jda_pkg::sat32(crd_r[0]);
          o_det_r  <= det_r;
          o_last_r <= row_r == dim_r - 2'd1;
          o_lp_r   <= lp_r;
          row_r    <= row_r + 2'd1;
          for (int k = 0; k < 6; k++) adj_r[k] <= adj_r[k + 3];
          crd_r[0] <= crd_r[1];
          crd_r[1] <= crd_r[2];
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/jacobian_det_adjugate_accumulator_top.sv */
// Flow: a node word's products are registered, then added into the accumulators; a point's rows
// follow its last node after the back-end step sequence for the point's dimension.
// Throughput: one node word per cycle while the point queue has room; points complete at
// the rate of the shared 48x16 digit multiplier in the back end.
// Reset: synchronous active-low; clears accumulators, queue and dim_mode (to 3).
`timescale 1ns / 1ps
module jacobian_det_adjugate_accumulator_top #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  jda_in_if.sink     in_ch,
  jda_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic [1:0]       dim_mode_r;
  logic             push, pop;
  jda_pkg::pt_t     push_data, head;
  jda_pkg::q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) dim_mode_r <= jda_pkg::DIM_THREE;
    else if (cfg_we) dim_mode_r <= cfg_wdata;
  end

  jda_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dim_mode  (dim_mode_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  jda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  jda_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full || pop) else $error("point queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("point queue underflow");

  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_row |=> out_ch.valid)
    else $error("row word missing after non-final row");

endmodule
